// File: hdl/clb_pkg.sv
// Shared types and character constants for the comment and literal blanker.
package clb_pkg;

    // Character codes the lexer looks for
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Output queue depth
    localparam int QUEUE_DEPTH = 3;

    // Lexer mode, one-hot
    typedef enum logic [8:0] {
        MODE_CODE       = 9'b000000001,
        MODE_CODE_SLASH = 9'b000000010,
        MODE_LINE       = 9'b000000100,
        MODE_BLOCK      = 9'b000001000,
        MODE_BLOCK_STAR = 9'b000010000,
        MODE_STRING     = 9'b000100000,
        MODE_CHAR       = 9'b001000000,
        MODE_STRING_ESC = 9'b010000000,
        MODE_CHAR_ESC   = 9'b100000000
    } mode_t;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } result_t;

    // Results handed from the lexer to the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

// File: hdl/clb_lexer.sv
// Input register, lexer mode register and per-byte blanking logic.
module clb_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic [1:0]          free_slots,
    output clb_pkg::push_t      push
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    clb_pkg::mode_t     mode_reg;
    clb_pkg::mode_t     mode_next;
    clb_pkg::mode_t     step_mode;

    logic               consume;
    logic [1:0]         n;
    logic [7:0]         b0;
    logic [7:0]         b1;

    logic               code_emit;
    logic [7:0]         code_out;
    clb_pkg::mode_t     code_mode;

    logic [7:0]         c;
    logic               last;
    logic               is_nl;
    logic [7:0]         nl_or_space;

    assign c           = in_byte_reg;
    assign last        = in_last_reg;
    assign is_nl       = (c == clb_pkg::CH_NL);
    assign nl_or_space = is_nl ? clb_pkg::CH_NL : clb_pkg::CH_SPACE;

    // Behaviour of a byte seen in plain code
    always_comb
    begin
        code_emit = 1'b1;
        code_out  = c;
        code_mode = clb_pkg::MODE_CODE;
        if (c == clb_pkg::CH_SLASH)
        begin
            code_emit = last;
            if (!last)
            begin
                code_mode = clb_pkg::MODE_CODE_SLASH;
            end
        end
        else if (c == clb_pkg::CH_DQUOTE)
        begin
            code_out  = clb_pkg::CH_SPACE;
            code_mode = clb_pkg::MODE_STRING;
        end
        else if (c == clb_pkg::CH_SQUOTE)
        begin
            code_out  = clb_pkg::CH_SPACE;
            code_mode = clb_pkg::MODE_CHAR;
        end
    end

    // One lexer step on the registered byte
    always_comb
    begin
        n         = 2'd1;
        b0        = clb_pkg::CH_SPACE;
        b1        = clb_pkg::CH_SPACE;
        step_mode = clb_pkg::MODE_CODE;
        case (mode_reg)
            clb_pkg::MODE_CODE_SLASH:
            begin
                if (c == clb_pkg::CH_SLASH || c == clb_pkg::CH_STAR)
                begin
                    n         = 2'd2;
                    step_mode = (c == clb_pkg::CH_SLASH) ? clb_pkg::MODE_LINE
                                                         : clb_pkg::MODE_BLOCK;
                end
                else
                begin
                    n         = 2'd1 + {1'b0, code_emit};
                    b0        = clb_pkg::CH_SLASH;
                    b1        = code_out;
                    step_mode = code_mode;
                end
            end
            clb_pkg::MODE_LINE:
            begin
                b0        = nl_or_space;
                step_mode = is_nl ? clb_pkg::MODE_CODE : clb_pkg::MODE_LINE;
            end
            clb_pkg::MODE_BLOCK,
            clb_pkg::MODE_BLOCK_STAR:
            begin
                if (mode_reg == clb_pkg::MODE_BLOCK_STAR && c == clb_pkg::CH_SLASH)
                begin
                    step_mode = clb_pkg::MODE_CODE;
                end
                else if (c == clb_pkg::CH_STAR)
                begin
                    step_mode = clb_pkg::MODE_BLOCK_STAR;
                end
                else
                begin
                    b0        = nl_or_space;
                    step_mode = clb_pkg::MODE_BLOCK;
                end
            end
            clb_pkg::MODE_STRING:
            begin
                b0 = nl_or_space;
                if (c == clb_pkg::CH_BSLASH && !last)
                begin
                    step_mode = clb_pkg::MODE_STRING_ESC;
                end
                else if (c == clb_pkg::CH_DQUOTE)
                begin
                    step_mode = clb_pkg::MODE_CODE;
                end
                else
                begin
                    step_mode = clb_pkg::MODE_STRING;
                end
            end
            clb_pkg::MODE_CHAR:
            begin
                b0 = nl_or_space;
                if (c == clb_pkg::CH_BSLASH && !last)
                begin
                    step_mode = clb_pkg::MODE_CHAR_ESC;
                end
                else if (c == clb_pkg::CH_SQUOTE)
                begin
                    step_mode = clb_pkg::MODE_CODE;
                end
                else
                begin
                    step_mode = clb_pkg::MODE_CHAR;
                end
            end
            clb_pkg::MODE_STRING_ESC:
            begin
                step_mode = clb_pkg::MODE_STRING;
            end
            clb_pkg::MODE_CHAR_ESC:
            begin
                step_mode = clb_pkg::MODE_CHAR;
            end
            default:
            begin
                n         = {1'b0, code_emit};
                b0        = code_out;
                step_mode = code_mode;
            end
        endcase
    end

    // Take the byte only when the queue has room for all its results
    assign consume       = in_valid_reg && (n <= free_slots);
    assign s_tready      = !in_valid_reg || consume;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign mode_next     = consume ? (last ? clb_pkg::MODE_CODE : step_mode) : mode_reg;

    // Results to the queue; run_last and text_done sit on the final one
    always_comb
    begin
        push.count          = consume ? n : 2'd0;
        push.res0.out_byte  = b0;
        push.res0.run_last  = (n == 2'd1);
        push.res0.text_done = (n == 2'd1) && last;
        push.res1.out_byte  = b1;
        push.res1.run_last  = 1'b1;
        push.res1.text_done = last;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= clb_pkg::MODE_CODE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

// File: hdl/clb_out_queue.sv
// Three-entry result queue that can take two beats a cycle while it has room and gives one.
module clb_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  clb_pkg::push_t      push,
    output logic [1:0]          free_slots,
    output logic                m_tvalid,
    input  logic                m_tready,
    output clb_pkg::result_t    head
);

    localparam int DEPTH = clb_pkg::QUEUE_DEPTH;

    clb_pkg::result_t   q_reg  [DEPTH];
    clb_pkg::result_t   q_next [DEPTH];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic [1:0]         count_after_pop;
    logic               pop;

    assign m_tvalid        = (count_reg != 2'd0);
    assign head            = q_reg[0];
    assign pop             = m_tvalid && m_tready;
    assign free_slots      = 2'(DEPTH) - count_reg;
    assign count_after_pop = count_reg - {1'b0, pop};
    assign count_next      = count_after_pop + push.count;

    // Shift on a pop, then append the new beats behind the survivors
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push.count != 2'd0 && 2'(i) == count_after_pop)
            begin
                q_next[i] = push.res0;
            end
            if (push.count == 2'd2 && 2'(i) == count_after_pop + 2'd1)
            begin
                q_next[i] = push.res1;
            end
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Queue entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// File: hdl/c_comment_literal_blanker.sv
// Top level of the C/C++ comment and literal blanker.
//
// Source text enters on the s_ channel, one byte per beat, with s_tlast on
// the final byte of a text. The m_ channel returns the text with comments
// and string or character literals (delimiters included) replaced by
// spaces; newlines are kept unless escaped in a literal. Each input beat
// yields zero, one or two output beats: a '/' in code is held until the
// next byte shows whether it opens a comment. m_tlast marks the last
// output beat of an input beat; m_tuser marks the final one of a text.
//
// An accepted byte is registered, then its results enter the three-entry
// result queue, that absorbs the extra beat of a byte giving two results.
// One byte is accepted per cycle while the queue has room.
// s_tready depends only on registered state, not on m_tready.
// Reset empties the input register and the queue and puts the lexer in
// code mode. When the receiver stalls, results collect in the queue and
// s_tready falls once the queue cannot take the pending byte's results.
module c_comment_literal_blanker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // run_last
    output logic [0:0]  m_tuser     // [0] text_done
);

    clb_pkg::push_t     push;
    logic [1:0]         free_slots;
    clb_pkg::result_t   head;

    // Lexer stage
    clb_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .free_slots (free_slots),
        .push       (push)
    );

    // Result queue
    clb_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free_slots (free_slots),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head       (head)
    );

    assign m_tdata    = head.out_byte;
    assign m_tlast    = head.run_last;
    assign m_tuser[0] = head.text_done;

endmodule
